// File: sv/qsm_pkg.sv
`timescale 1ns / 1ps

package qsm_pkg;

   localparam int SQRT_STEPS = 17;   // root bits of a 33-bit sum of squares
   localparam int DIV_STEPS  = 15;   // quotient bits, magnitude at most 2^14

   typedef enum logic [0:0] {
      CSR_SCALE_FLOOR = 1'b0,
      CSR_NORM_FLOOR  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] scale;
      logic [3:0][15:0] quat;
   } carry_type;

   typedef struct packed {
      carry_type        c;
      logic [3:0][30:0] sq;
   } sqr_type;

   typedef struct packed {
      carry_type   c;
      logic [32:0] rem;
      logic [32:0] root;
   } root_type;

   typedef struct packed {
      carry_type        c;
      logic             norm;
      logic [16:0]      n;
      logic [3:0][29:0] dvd;
      logic [3:0][17:0] rem;
      logic [3:0][14:0] quo;
   } div_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] scale;
      logic [3:0][15:0] cq;
   } comp_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] scale;
      logic [8:0][31:0] prod;
   } prod_type;

   typedef struct packed {
      logic [2:0][31:0]      pos;
      logic [2:0][31:0]      scale;
      logic [2:0][2:0][27:0] rt;
   } rot_type;

   typedef struct packed {
      logic [2:0][31:0]      pos;
      logic [2:0][2:0][59:0] p;
   } mul_type;

endpackage

// File: sv/quat_scale_pos_to_matrix.sv
`timescale 1ns / 1ps

// Part-transform composer. Each req_ transfer carries a position, a quaternion
// (Q2.14, possibly unnormalized or zero) and a per-axis scale; each rsp_ transfer
// carries the 4x3 affine transform: three rotation columns times scale, then
// the position unchanged. Rows saturate to signed 32 bits.
// Channels: req_ and rsp_ are stream channels (tvalid/tready/tdata); csr_ writes
// scale_floor (index 0) and norm_floor (index 1) and is always ready.
// An item passes the squares and sum stages, the bit-per-stage square root of
// SQRT_STEPS stages, the dividend setup stage, the four bit-per-stage dividers
// of DIV_STEPS stages, then select, products, rotation terms, scale multiply and
// round/saturate, one stage each. One item per cycle goes in unless rsp_ stalls.
// Reset clears all stage valid bits and loads scale_floor = 1, norm_floor = 2.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
module quat_scale_pos_to_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // row0_x..z, row1_x..z, row2_x..z, trans_x, trans_y, trans_z
   output logic [383:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam logic [31:0] UNIT_SCALE = 32'(1) << FRAC_BITS;

   logic en;

   // configuration
   logic [15:0] scale_floor_ff;
   logic [13:0] norm_floor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_floor_ff <= 16'd1;
         norm_floor_ff  <= 14'd2;
      end else if (csr_valid) begin
         if (csr_index == qsm_pkg::CSR_SCALE_FLOOR) begin
            scale_floor_ff <= csr_data;
         end else begin
            norm_floor_ff <= csr_data[13:0];
         end
      end
   end

   // advance everything unless a finished result is held back
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage A: squares, tiny-scale check
   qsm_pkg::sqr_type a_in, a_ff;
   logic             av_ff;

   always_comb begin
      logic        tiny;
      logic [31:0] s;
      logic [31:0] sabs;
      logic [31:0] prod;
      tiny          = 1'b0;
      a_in.c.pos    = req_tdata[95:0];
      a_in.c.quat   = req_tdata[159:96];
      a_in.c.scale  = req_tdata[255:160];
      for (int i = 0; i < 3; i++) begin
         s    = req_tdata[160 + 32*i +: 32];
         sabs = s[31] ? (~s + 32'd1) : s;
         if (sabs < {16'd0, scale_floor_ff}) tiny = 1'b1;
      end
      if (tiny) begin
         for (int i = 0; i < 3; i++) a_in.c.scale[i] = UNIT_SCALE;
      end
      for (int i = 0; i < 4; i++) begin
         prod = 32'($signed(req_tdata[96 + 16*i +: 16]) * $signed(req_tdata[96 + 16*i +: 16]));
         a_in.sq[i] = prod[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) av_ff <= 1'b0;
      else if (en) av_ff <= req_tvalid;
      if (en) a_ff <= a_in;
   end

   // stage B: sum of squares, seed the root
   qsm_pkg::root_type rt_ff [0:qsm_pkg::SQRT_STEPS];
   qsm_pkg::root_type rt_in [1:qsm_pkg::SQRT_STEPS];
   logic [qsm_pkg::SQRT_STEPS:0] rv_ff;

   always_ff @(posedge clock) begin
      if (reset) rv_ff[0] <= 1'b0;
      else if (en) rv_ff[0] <= av_ff;
      if (en) begin
         rt_ff[0].c    <= a_ff.c;
         rt_ff[0].rem  <= 33'(a_ff.sq[0]) + 33'(a_ff.sq[1]) + 33'(a_ff.sq[2])
                          + 33'(a_ff.sq[3]);
         rt_ff[0].root <= 33'd0;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < qsm_pkg::SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [33:0] BIT = 34'(1) << (2 * (qsm_pkg::SQRT_STEPS - 1 - k));
      always_comb begin
         logic [33:0] trial;
         trial           = {1'b0, rt_ff[k].root} + BIT;
         rt_in[k+1].c    = rt_ff[k].c;
         if ({1'b0, rt_ff[k].rem} >= trial) begin
            rt_in[k+1].rem  = 33'({1'b0, rt_ff[k].rem} - trial);
            rt_in[k+1].root = 33'(({1'b0, rt_ff[k].root} >> 1) + BIT);
         end else begin
            rt_in[k+1].rem  = rt_ff[k].rem;
            rt_in[k+1].root = rt_ff[k].root >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) rv_ff[k+1] <= 1'b0;
         else if (en) rv_ff[k+1] <= rv_ff[k];
         if (en) rt_ff[k+1] <= rt_in[k+1];
      end
   end

   // divider setup: rounded dividend |q| * 2^14 + n/2
   qsm_pkg::div_type dv_ff [0:qsm_pkg::DIV_STEPS];
   qsm_pkg::div_type dv_in [0:qsm_pkg::DIV_STEPS];
   logic [qsm_pkg::DIV_STEPS:0] dvv_ff;

   always_comb begin
      logic [16:0] n;
      logic [15:0] q;
      logic [15:0] qa;
      logic [29:0] d;
      n           = rt_ff[qsm_pkg::SQRT_STEPS].root[16:0];
      dv_in[0].c  = rt_ff[qsm_pkg::SQRT_STEPS].c;
      dv_in[0].n  = n;
      dv_in[0].norm = n > {3'd0, norm_floor_ff};
      for (int i = 0; i < 4; i++) begin
         q  = rt_ff[qsm_pkg::SQRT_STEPS].c.quat[i];
         qa = q[15] ? (~q + 16'd1) : q;
         d  = {qa, 14'd0} + 30'(n >> 1);
         dv_in[0].dvd[i] = d;
         dv_in[0].rem[i] = 18'(d[29:15]);
         dv_in[0].quo[i] = 15'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dvv_ff[0] <= 1'b0;
      else if (en) dvv_ff[0] <= rv_ff[qsm_pkg::SQRT_STEPS];
      if (en) dv_ff[0] <= dv_in[0];
   end

   // four restoring dividers, one quotient bit per stage
   for (genvar k = 0; k < qsm_pkg::DIV_STEPS; k++) begin : g_div
      localparam int J = qsm_pkg::DIV_STEPS - 1 - k;
      always_comb begin
         logic [17:0] r;
         dv_in[k+1] = dv_ff[k];
         for (int i = 0; i < 4; i++) begin
            r = {dv_ff[k].rem[i][16:0], dv_ff[k].dvd[i][J]};
            if (r >= {1'b0, dv_ff[k].n}) begin
               dv_in[k+1].rem[i]    = r - {1'b0, dv_ff[k].n};
               dv_in[k+1].quo[i][J] = 1'b1;
            end else begin
               dv_in[k+1].rem[i]    = r;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dvv_ff[k+1] <= 1'b0;
         else if (en) dvv_ff[k+1] <= dvv_ff[k];
         if (en) dv_ff[k+1] <= dv_in[k+1];
      end
   end

   // stage C: pick normalized or raw components
   qsm_pkg::comp_type c_in, c_ff;
   logic              cv_ff;
   qsm_pkg::div_type  dl;

   assign dl = dv_ff[qsm_pkg::DIV_STEPS];

   always_comb begin
      logic [15:0] m;
      c_in.pos   = dl.c.pos;
      c_in.scale = dl.c.scale;
      for (int i = 0; i < 4; i++) begin
         m = {1'b0, dl.quo[i]};
         if (dl.norm) c_in.cq[i] = dl.c.quat[i][15] ? (~m + 16'd1) : m;
         else         c_in.cq[i] = dl.c.quat[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cv_ff <= 1'b0;
      else if (en) cv_ff <= dvv_ff[qsm_pkg::DIV_STEPS];
      if (en) c_ff <= c_in;
   end

   // stage D: component products
   qsm_pkg::prod_type d_in, d_ff;
   logic              dv2_ff;

   always_comb begin
      logic signed [15:0] x, y, z, w;
      x = $signed(c_ff.cq[0]);
      y = $signed(c_ff.cq[1]);
      z = $signed(c_ff.cq[2]);
      w = $signed(c_ff.cq[3]);
      d_in.pos     = c_ff.pos;
      d_in.scale   = c_ff.scale;
      d_in.prod[0] = 32'(x * x);
      d_in.prod[1] = 32'(y * y);
      d_in.prod[2] = 32'(z * z);
      d_in.prod[3] = 32'(x * y);
      d_in.prod[4] = 32'(z * w);
      d_in.prod[5] = 32'(x * z);
      d_in.prod[6] = 32'(y * w);
      d_in.prod[7] = 32'(y * z);
      d_in.prod[8] = 32'(x * w);
   end

   always_ff @(posedge clock) begin
      if (reset) dv2_ff <= 1'b0;
      else if (en) dv2_ff <= cv_ff;
      if (en) d_ff <= d_in;
   end

   // stage E: rotation terms in Q8.28, rounded to Q8.20; rt[i][j] holds R[j][i]
   qsm_pkg::rot_type e_in, e_ff;
   logic             ev_ff;

   always_comb begin
      logic signed [35:0] xx, yy, zz, xy, zw, xz, yw, yz, xw;
      logic signed [35:0] r [3][3];
      localparam logic signed [35:0] DIAG = 36'sd268435584;  // 2^28 + rounding 2^7
      localparam logic signed [35:0] HALF = 36'sd128;
      xx = 36'($signed(d_ff.prod[0]));
      yy = 36'($signed(d_ff.prod[1]));
      zz = 36'($signed(d_ff.prod[2]));
      xy = 36'($signed(d_ff.prod[3]));
      zw = 36'($signed(d_ff.prod[4]));
      xz = 36'($signed(d_ff.prod[5]));
      yw = 36'($signed(d_ff.prod[6]));
      yz = 36'($signed(d_ff.prod[7]));
      xw = 36'($signed(d_ff.prod[8]));
      r[0][0] = DIAG - ((yy + zz) <<< 1);
      r[0][1] = ((xy + zw) <<< 1) + HALF;
      r[0][2] = ((xz - yw) <<< 1) + HALF;
      r[1][0] = ((xy - zw) <<< 1) + HALF;
      r[1][1] = DIAG - ((xx + zz) <<< 1);
      r[1][2] = ((yz + xw) <<< 1) + HALF;
      r[2][0] = ((xz + yw) <<< 1) + HALF;
      r[2][1] = ((yz - xw) <<< 1) + HALF;
      r[2][2] = DIAG - ((xx + yy) <<< 1);
      e_in.pos   = d_ff.pos;
      e_in.scale = d_ff.scale;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) e_in.rt[i][j] = r[i][j][35:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ev_ff <= 1'b0;
      else if (en) ev_ff <= dv2_ff;
      if (en) e_ff <= e_in;
   end

   // stage F: scale multiply
   qsm_pkg::mul_type f_in, f_ff;
   logic             fv_ff;

   always_comb begin
      f_in.pos = e_ff.pos;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            f_in.p[i][j] = 60'($signed(e_ff.rt[i][j]) * $signed(e_ff.scale[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fv_ff <= 1'b0;
      else if (en) fv_ff <= ev_ff;
      if (en) f_ff <= f_in;
   end

   // stage G: round, saturate, output register
   logic [383:0] g_in, g_ff;
   logic         gv_ff;

   always_comb begin
      logic signed [60:0] t;
      logic signed [40:0] sh;
      g_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            t  = 61'($signed(f_ff.p[i][j])) + 61'sd524288;
            sh = 41'(t >>> 20);
            if (sh > 41'sd2147483647)       g_in[32*(3*i+j) +: 32] = 32'h7FFF_FFFF;
            else if (sh < -41'sd2147483648) g_in[32*(3*i+j) +: 32] = 32'h8000_0000;
            else                            g_in[32*(3*i+j) +: 32] = sh[31:0];
         end
      end
      g_in[383:288] = f_ff.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) gv_ff <= 1'b0;
      else if (en) gv_ff <= fv_ff;
      if (en) g_ff <= g_in;
   end

   assign rsp_tvalid = gv_ff;
   assign rsp_tdata  = g_ff;

   // a held result freezes the root, divider and select stage valid bits
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rv_ff) && $stable(dvv_ff) && $stable(cv_ff)))
      else $error("pipeline moved during stall");

   // a normalized component never exceeds unit magnitude
   a_norm_bound : assert property (@(posedge clock) disable iff (reset)
      (dvv_ff[qsm_pkg::DIV_STEPS] && dl.norm) |->
      (dl.quo[0] <= 15'd16384 && dl.quo[1] <= 15'd16384 &&
       dl.quo[2] <= 15'd16384 && dl.quo[3] <= 15'd16384))
      else $error("normalized component out of range");

   // the root never exceeds 2^16
   a_root_bound : assert property (@(posedge clock) disable iff (reset)
      rv_ff[qsm_pkg::SQRT_STEPS] |-> (rt_ff[qsm_pkg::SQRT_STEPS].root <= 33'd65536))
      else $error("square root out of range");

   // nothing comes out right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int  PIPE_DEPTH  = 40;
   localparam int  DRAIN_WAIT  = PIPE_DEPTH + 20;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  RAND_ITEMS  = 1500;
   localparam int  RAND_PHASES = 5;
   localparam int  ONE         = 1 << 16;

   // One req_ transfer; declared top down so pos_x lands in the lowest bits.
   typedef struct packed {
      logic signed [31:0] scale_z;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_x;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } part_in_type;

   // One rsp_ transfer: word 0 is row0_x, word 11 is trans_z.
   typedef logic [11:0][31:0] xform_type;

   // One directed row: stimulus and, where obvious, the typed-in answer.
   typedef struct {
      part_in_type part;
      bit          has_typed;
      xform_type   typed;
   } dir_row_type;

   string field_name [12] = '{"row0_x", "row0_y", "row0_z", "row1_x", "row1_y", "row1_z",
                              "row2_x", "row2_y", "row2_z", "trans_x", "trans_y", "trans_z"};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;   // pos_x,y,z, quat_x,y,z,w, scale_x,y,z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [383:0] rsp_tdata;        // row0_x..z, row1_x..z, row2_x..z, trans_x,y,z
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [0:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   // Our copy of the two registers.
   logic [15:0]  scale_floor_q;
   logic [13:0]  norm_floor_q;

   xform_type    xform_q [$];      // expected transforms, oldest first
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           quiet = 1'b0;     // no idling on either side
   int           stall_left = 0;

   quat_scale_pos_to_matrix dut (.*);

   always #2 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint sqrt_floor(longint v);
      longint r;
      longint t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Rotation term in Q4.28 times a scale, rounded twice, saturated.
   function automatic logic [31:0] scaled_term(longint r28, longint s);
      longint r20;
      longint p;
      r20 = (r28 + 128) >>> 8;
      p   = (r20 * s + (longint'(1) << 19)) >>> 20;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   function automatic xform_type compose_xform(part_in_type it);
      longint    s [3];
      longint    q [4];
      longint    r [3][3];
      longint    sumsq;
      longint    n;
      longint    mag;
      bit        tiny;
      xform_type res;
      s[0] = it.scale_x; s[1] = it.scale_y; s[2] = it.scale_z;
      tiny = 1'b0;
      foreach (s[i]) if ((s[i] < 0 ? -s[i] : s[i]) < longint'(scale_floor_q)) tiny = 1'b1;
      if (tiny) foreach (s[i]) s[i] = ONE;
      q[0] = it.quat_x; q[1] = it.quat_y; q[2] = it.quat_z; q[3] = it.quat_w;
      sumsq = 0;
      foreach (q[i]) sumsq += q[i] * q[i];
      n = sqrt_floor(sumsq);
      // Normalize with rounding half away from zero.
      if (n > longint'(norm_floor_q))
         foreach (q[i]) begin
            mag  = (((q[i] < 0 ? -q[i] : q[i]) << 14) + (n >> 1)) / n;
            q[i] = q[i] < 0 ? -mag : mag;
         end
      r[0][0] = (longint'(1) << 28) - 2 * (q[1] * q[1] + q[2] * q[2]);
      r[0][1] = 2 * (q[0] * q[1] - q[2] * q[3]);
      r[0][2] = 2 * (q[0] * q[2] + q[1] * q[3]);
      r[1][0] = 2 * (q[0] * q[1] + q[2] * q[3]);
      r[1][1] = (longint'(1) << 28) - 2 * (q[0] * q[0] + q[2] * q[2]);
      r[1][2] = 2 * (q[1] * q[2] - q[0] * q[3]);
      r[2][0] = 2 * (q[0] * q[2] - q[1] * q[3]);
      r[2][1] = 2 * (q[1] * q[2] + q[0] * q[3]);
      r[2][2] = (longint'(1) << 28) - 2 * (q[0] * q[0] + q[1] * q[1]);
      // Row i is column i of the rotation times scale i.
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            res[i * 3 + j] = scaled_term(r[j][i], s[i]);
      res[9] = it.pos_x; res[10] = it.pos_y; res[11] = it.pos_z;
      return res;
   endfunction

   // Check each rsp_ transfer against the oldest expectation; drive stall bursts.
   always @(posedge clock) begin
      xform_type want;
      xform_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (xform_q.size() == 0) begin
               $error("unexpected transform transfer %h", got);
               fail_count++;
            end else begin
               want = xform_q.pop_front();
               for (int k = 0; k < 12; k++)
                  if (got[k] !== want[k]) begin
                     $error("%s: expected %h, got %h", field_name[k], want[k], got[k]);
                     fail_count++;
                  end
            end
         end
         if (quiet) begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(qsm_pkg::csr_idx_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == qsm_pkg::CSR_SCALE_FLOOR) scale_floor_q = val;
      else norm_floor_q = val[13:0];
      @(posedge clock);
   endtask

   // Present one part; hold tvalid across back-to-back transfers.
   task automatic send_part(part_in_type it, bit has_typed, xform_type typed);
      xform_type pred;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it;
      do @(posedge clock); while (!req_tready);
      pred = compose_xform(it);
      if (has_typed && pred !== typed) begin
         $error("directed row: predictor %h disagrees with typed value %h", pred, typed);
         fail_count++;
      end
      xform_q.push_back(has_typed ? typed : pred);
   endtask

   // Walk one table of directed rows.
   task automatic run_rows(dir_row_type rows [$]);
      foreach (rows[k]) send_part(rows[k].part, rows[k].has_typed, rows[k].typed);
   endtask

   // Wait until the block is empty before touching the registers.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (xform_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic part_in_type make_part(logic [15:0] qx, logic [15:0] qy,
                                             logic [15:0] qz, logic [15:0] qw,
                                             logic [31:0] s, logic [31:0] p);
      part_in_type it;
      it = '{scale_z: s, scale_y: s, scale_x: s, quat_w: qw, quat_z: qz, quat_y: qy,
             quat_x: qx, pos_z: p, pos_y: ~p, pos_x: p};
      return it;
   endfunction

   function automatic xform_type diag_xform(logic [31:0] d, logic [31:0] p);
      xform_type x;
      x = '0;
      x[0] = d; x[4] = d; x[8] = d;
      x[9] = p; x[10] = ~p; x[11] = p;
      return x;
   endfunction

   function automatic logic [31:0] rand_scale(logic [15:0] floor_v);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
         2: return {16'h0, floor_v} + $urandom_range(0, 2) - 1;
         3: return -({16'h0, floor_v} + $urandom_range(0, 2) - 1);
         4: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
         default: return ($urandom_range(0, 1) ? ONE : -ONE) + $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic logic [15:0] rand_quat();
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom);
         2: return 16'($urandom_range(0, 6) - 3);
         3: return 16'($urandom_range(0, 32768) - 16384);
         4: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'h0;
      endcase
   endfunction

   initial begin
      dir_row_type rows [$];
      part_in_type it;
      logic [15:0] qv [4];
      int          per_phase;

      scale_floor_q = 1;
      norm_floor_q  = 2;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset values of the registers.
      // Zero quaternion with unit scale gives identity.
      rows.push_back('{make_part(0, 0, 0, 0, ONE, 0), 1'b1, diag_xform(ONE, 0)});
      // Zero scale falls below the floor and becomes unit; extreme position.
      rows.push_back('{make_part(0, 0, 0, 0, 0, 32'h7fffffff), 1'b1,
                       diag_xform(ONE, 32'h7fffffff)});
      // Most negative scale is used as given.
      rows.push_back('{make_part(0, 0, 0, 0, 32'h80000000, 32'h80000000), 1'b1,
                       diag_xform(32'h80000000, 32'h80000000)});
      // Unit w quaternion, largest scale.
      rows.push_back('{make_part(0, 0, 0, 16384, 32'h7fffffff, 32'h12345678), 1'b0, '0});
      rows.push_back('{make_part(16'h8000, 16'h8000, 16'h8000, 16'h8000, ONE, 5), 1'b0, '0});
      rows.push_back('{make_part(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, ONE * 3, 6),
                       1'b0, '0});
      // Tiny quaternion at or below the floor is used raw.
      rows.push_back('{make_part(1, 0, 0, 1, ONE, 7), 1'b0, '0});
      rows.push_back('{make_part(2, 0, 0, 0, ONE, 8), 1'b0, '0});
      rows.push_back('{make_part(16'h7fff, 0, 0, 0, -ONE, 9), 1'b0, '0});
      rows.push_back('{make_part(0, 16'h8000, 11585, 0, 32'hffff0000, 10), 1'b0, '0});
      run_rows(rows);
      rows.delete();
      drain;

      // Extremes of the registers: large quaternions still pass the norm floor; small ones are used raw.
      write_csr(qsm_pkg::CSR_NORM_FLOOR, 16'h3fff);
      write_csr(qsm_pkg::CSR_SCALE_FLOOR, 16'hffff);
      rows.push_back('{make_part(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff, 11),
                       1'b0, '0});
      rows.push_back('{make_part(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'h80000000, 12),
                       1'b0, '0});
      rows.push_back('{make_part(16'h8000, 0, 0, 0, 32'h0000fffe, 13), 1'b0, '0});
      rows.push_back('{make_part(0, 0, 16'h8000, 0, 32'hffff0001, 14), 1'b0, '0});
      rows.push_back('{make_part(100, 200, 300, 400, 32'h0000ffff, 15), 1'b0, '0});
      run_rows(rows);
      rows.delete();
      drain;
      write_csr(qsm_pkg::CSR_SCALE_FLOOR, 16'h0);
      write_csr(qsm_pkg::CSR_NORM_FLOOR, 16'h0);
      rows.push_back('{make_part(0, 0, 0, 0, 0, 16), 1'b0, '0});
      rows.push_back('{make_part(1, 0, 0, 0, 0, 17), 1'b0, '0});
      rows.push_back('{make_part(0, 0, 0, 16'h8000, 32'h00000001, 18), 1'b0, '0});
      run_rows(rows);
      rows.delete();
      drain;

      // Random phases, each under a fresh register setting; the last one runs
      // without idling on either side.
      per_phase = RAND_ITEMS / RAND_PHASES;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0: write_csr(qsm_pkg::CSR_SCALE_FLOOR, 16'hffff);
            1: write_csr(qsm_pkg::CSR_SCALE_FLOOR, 16'h0);
            default: write_csr(qsm_pkg::CSR_SCALE_FLOOR, 16'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0: write_csr(qsm_pkg::CSR_NORM_FLOOR, 16'h3fff);
            1: write_csr(qsm_pkg::CSR_NORM_FLOOR, 16'($urandom_range(0, 3)));
            default: write_csr(qsm_pkg::CSR_NORM_FLOOR, 16'($urandom));
         endcase
         quiet = (ph == RAND_PHASES - 1);
         for (int k = 0; k < per_phase; k++) begin
            foreach (qv[i]) qv[i] = rand_quat();
            it.quat_x = qv[0]; it.quat_y = qv[1]; it.quat_z = qv[2]; it.quat_w = qv[3];
            it.scale_x = rand_scale(scale_floor_q);
            it.scale_y = $urandom_range(0, 3) == 0 ? rand_scale(scale_floor_q) : $urandom;
            it.scale_z = rand_scale(scale_floor_q);
            it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
            send_part(it, 0, '0);
         end
         drain;
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
